@@ rtl/svo_pkg.sv @@
// Package: types, codes and constants of the homing position servo.
`timescale 1ns / 1ps

package svo_pkg;

  localparam int PosBits    = 16;
  // Signed width that holds position, clamped target and their difference.
  localparam int CalcBits   = ((PosBits > 16) ? PosBits : 16) + 3;
  localparam int HomeMargin = 3;

  localparam logic [14:0] DeadbandRst   = 15'd2;
  localparam logic [14:0] AngleLimitRst = 15'd170;
  localparam logic [15:0] RunDutyRst    = 16'd1000;
  localparam logic [15:0] StopDutyRst   = 16'd10000;

  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_INDEX = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_DEADBAND    = 2'd0,
    REG_ANGLE_LIMIT = 2'd1,
    REG_RUN_DUTY    = 2'd2,
    REG_STOP_DUTY   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [14:0] deadband;
    logic [14:0] angle_limit;
    logic [15:0] run_duty;
    logic [15:0] stop_duty;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               b_level;
    logic signed [15:0] target_angle;
  } item_t;

  typedef struct packed {
    logic [15:0]        duty_out;
    logic               spin_ccw;
    logic signed [15:0] position_out;
    logic               is_calibrated;
    logic               is_tracking;
  } result_t;

endpackage

@@ rtl/svo_if.sv @@
// Interfaces: event input channel and result output channel.
`timescale 1ns / 1ps

interface svo_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               b_level;
  logic signed [15:0] target_angle;

  modport source (output valid, mode, b_level, target_angle, input ready);
  modport sink   (input valid, mode, b_level, target_angle, output ready);
endinterface

interface svo_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        duty_out;
  logic               spin_ccw;
  logic signed [15:0] position_out;
  logic               is_calibrated;
  logic               is_tracking;

  modport source (output valid, duty_out, spin_ccw, position_out, is_calibrated,
                  is_tracking, input ready);
  modport sink   (input valid, duty_out, spin_ccw, position_out, is_calibrated,
                  is_tracking, output ready);
endinterface

@@ rtl/svo_cfg.sv @@
// Configuration registers of the servo.
`timescale 1ns / 1ps

module svo_cfg
  import svo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband    <= DeadbandRst;
      cfg_q.angle_limit <= AngleLimitRst;
      cfg_q.run_duty    <= RunDutyRst;
      cfg_q.stop_duty   <= StopDutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEADBAND:    cfg_q.deadband    <= cfg_data_i[14:0];
        REG_ANGLE_LIMIT: cfg_q.angle_limit <= cfg_data_i[14:0];
        REG_RUN_DUTY:    cfg_q.run_duty    <= cfg_data_i;
        REG_STOP_DUTY:   cfg_q.stop_duty   <= cfg_data_i;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/svo_core.sv @@
// Servo state and the single-pass event update: counting, homing, tracking.
`timescale 1ns / 1ps

module svo_core
  import svo_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [PosBits-1:0] pos_q, pos_d;
  logic               track_q, track_d;
  logic               calib_q, calib_d;
  logic               rev_q, rev_d;
  logic               dir_q, dir_d;
  logic [15:0]        duty_q, duty_d;

  logic signed [CalcBits-1:0] pos_s, lim_s, tgt_s, tgt_c, err_s, mag_s, db_s;
  logic [PosBits+15:0]        pos_ext;

  always_comb begin
    pos_s = CalcBits'(signed'(pos_q));
    lim_s = signed'(CalcBits'(cfg_i.angle_limit));
    db_s  = signed'(CalcBits'(cfg_i.deadband));
    tgt_s = CalcBits'(item_i.target_angle);
    // clamp target to the symmetric limit
    if (tgt_s > lim_s) begin
      tgt_c = lim_s;
    end else if (tgt_s < -lim_s) begin
      tgt_c = -lim_s;
    end else begin
      tgt_c = tgt_s;
    end
    err_s = tgt_c - pos_s;
    mag_s = (err_s < 0) ? -err_s : err_s;
  end

  always_comb begin
    pos_d   = pos_q;
    track_d = track_q;
    calib_d = calib_q;
    rev_d   = rev_q;
    dir_d   = dir_q;
    duty_d  = duty_q;
    if (step_i) begin
      unique case (item_i.mode)
        MODE_EDGE: begin
          pos_d = item_i.b_level ? pos_q + PosBits'(1) : pos_q - PosBits'(1);
        end
        MODE_INDEX: begin
          pos_d   = '0;
          calib_d = 1'b1;
        end
        MODE_TICK: begin
          if (!track_q) begin
            if (calib_q) begin
              duty_d  = cfg_i.stop_duty;
              track_d = 1'b1;
            end else begin
              duty_d = cfg_i.run_duty;
              // turn clockwise once past the homing threshold
              if (pos_s > lim_s + CalcBits'(HomeMargin) && !rev_q) begin
                rev_d = 1'b1;
                dir_d = 1'b0;
              end
            end
          end else if (mag_s > db_s) begin
            duty_d = cfg_i.run_duty;
            dir_d  = (err_s > 0);
          end else begin
            duty_d = cfg_i.stop_duty;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      track_q <= 1'b0;
      calib_q <= 1'b0;
      rev_q   <= 1'b0;
      dir_q   <= 1'b1;
      duty_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      track_q <= track_d;
      calib_q <= calib_d;
      rev_q   <= rev_d;
      dir_q   <= dir_d;
      duty_q  <= duty_d;
    end
  end

  assign pos_ext = {16'b0, pos_d};

  assign res_o.duty_out      = duty_d;
  assign res_o.spin_ccw      = dir_d;
  assign res_o.position_out  = signed'(pos_ext[15:0]);
  assign res_o.is_calibrated = calib_d;
  assign res_o.is_tracking   = track_d;

  a_index_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == MODE_INDEX |=> pos_q == '0 && calib_q)
    else $error("index item did not clear position and set calibrated");

  a_track_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_q |=> track_q)
    else $error("tracking phase dropped");

  a_track_needs_calib : assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_q |-> calib_q)
    else $error("tracking without calibration");

  a_idle_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(duty_q) && $stable(dir_q))
    else $error("state changed without an item");

endmodule

@@ rtl/homing_bang_bang_position_servo_top.sv @@
// Throughput: one item per cycle unless the output stalls. The result register advances
// whenever it is empty or being taken, and the input register loads whenever it is empty
// or advancing; an item's result is loaded into the result register as it advances.
// Reset: asynchronous, active low; position 0, homing, not calibrated,
// counterclockwise, duty 0, registers at their defaults.
`timescale 1ns / 1ps

module homing_bang_bang_position_servo_top
  import svo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  svo_in_if.sink      in_i,
  svo_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res;
  item_t   s1_item_q;
  logic    s1_valid_q;
  result_t out_res_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_ready;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || advance;

  svo_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  svo_core u_core (
    .clk_i,
    .rst_ni,
    .step_i (s1_valid_q && advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q.mode         <= in_i.mode;
      s1_item_q.b_level      <= in_i.b_level;
      s1_item_q.target_angle <= in_i.target_angle;
    end
    if (advance && s1_valid_q) begin
      out_res_q <= res;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.duty_out      = out_res_q.duty_out;
  assign out_o.spin_ccw      = out_res_q.spin_ccw;
  assign out_o.position_out  = out_res_q.position_out;
  assign out_o.is_calibrated = out_res_q.is_calibrated;
  assign out_o.is_tracking   = out_res_q.is_tracking;

endmodule

@@ dv/homing_servo_checker.sv @@
// Checker: mirrors the servo state, predicts each status item and compares it.
`timescale 1ns / 1ps

module homing_servo_checker
  import svo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  svo_in_if           in_mon,
  svo_out_if          out_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  cfg_t        regs_q;
  logic [15:0] pos_q;
  logic        tracking_q;
  logic        calibrated_q;
  logic        reversed_q;
  logic        ccw_q;
  logic [15:0] duty_q;
  result_t     status_due_q[$];

  // Apply one event to the mirrored servo state and return the status it reports.
  task automatic advance_servo(input item_t ev, output result_t st);
    int lim;
    int pos_s;
    int tgt;
    int err;
    int mag;
    lim   = int'(regs_q.angle_limit);
    pos_s = int'($signed(pos_q));
    tgt   = int'($signed(ev.target_angle));
    case (ev.mode)
      MODE_EDGE: begin
        pos_q = ev.b_level ? pos_q + 16'd1 : pos_q - 16'd1;
      end
      MODE_INDEX: begin
        pos_q        = '0;
        calibrated_q = 1'b1;
      end
      MODE_TICK: begin
        if (!tracking_q) begin
          if (!calibrated_q) begin
            duty_q = regs_q.run_duty;
            // reverse only once, after overshooting the limit plus the margin
            if (pos_s > lim + HomeMargin && !reversed_q) begin
              reversed_q = 1'b1;
              ccw_q      = 1'b0;
            end
          end
          if (calibrated_q) begin
            duty_q     = regs_q.stop_duty;
            tracking_q = 1'b1;
          end
        end else begin
          if (tgt > lim) tgt = lim;
          else if (tgt < -lim) tgt = -lim;
          err = tgt - pos_s;
          mag = (err < 0) ? -err : err;
          if (mag > int'(regs_q.deadband)) begin
            duty_q = regs_q.run_duty;
            ccw_q  = (err > 0);
          end else begin
            duty_q = regs_q.stop_duty;
          end
        end
      end
      default: ;
    endcase
    st.duty_out      = duty_q;
    st.spin_ccw      = ccw_q;
    st.position_out  = pos_q;
    st.is_calibrated = calibrated_q;
    st.is_tracking   = tracking_q;
  endtask

  task automatic compare_status(input result_t exp_st, input result_t got);
    if (got.duty_out !== exp_st.duty_out) begin
      $error("duty_out: expected %0d, got %0d", exp_st.duty_out, got.duty_out);
      fail_count_o++;
    end
    if (got.spin_ccw !== exp_st.spin_ccw) begin
      $error("spin_ccw: expected %0d, got %0d", exp_st.spin_ccw, got.spin_ccw);
      fail_count_o++;
    end
    if (got.position_out !== exp_st.position_out) begin
      $error("position_out: expected %0d, got %0d", exp_st.position_out, got.position_out);
      fail_count_o++;
    end
    if (got.is_calibrated !== exp_st.is_calibrated) begin
      $error("is_calibrated: expected %0d, got %0d", exp_st.is_calibrated,
             got.is_calibrated);
      fail_count_o++;
    end
    if (got.is_tracking !== exp_st.is_tracking) begin
      $error("is_tracking: expected %0d, got %0d", exp_st.is_tracking, got.is_tracking);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   ev;
    result_t st;
    result_t got;
    if (!rst_ni) begin
      regs_q.deadband    = DeadbandRst;
      regs_q.angle_limit = AngleLimitRst;
      regs_q.run_duty    = RunDutyRst;
      regs_q.stop_duty   = StopDutyRst;
      pos_q        = '0;
      tracking_q   = 1'b0;
      calibrated_q = 1'b0;
      reversed_q   = 1'b0;
      ccw_q        = 1'b1;
      duty_q       = '0;
      status_due_q.delete();
      pending_o    = 0;
    end else begin
      // take the status item first so it is never matched against this edge's event
      if (out_mon.valid && out_mon.ready) begin
        got.duty_out      = out_mon.duty_out;
        got.spin_ccw      = out_mon.spin_ccw;
        got.position_out  = out_mon.position_out;
        got.is_calibrated = out_mon.is_calibrated;
        got.is_tracking   = out_mon.is_tracking;
        if (status_due_q.size() == 0) begin
          $error("status item with no event pending: duty %0d position %0d",
                 got.duty_out, got.position_out);
          fail_count_o++;
        end else begin
          compare_status(status_due_q.pop_front(), got);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        ev.mode         = in_mon.mode;
        ev.b_level      = in_mon.b_level;
        ev.target_angle = in_mon.target_angle;
        advance_servo(ev, st);
        status_due_q.push_back(st);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEADBAND:    regs_q.deadband    = cfg_data_i[14:0];
          REG_ANGLE_LIMIT: regs_q.angle_limit = cfg_data_i[14:0];
          REG_RUN_DUTY:    regs_q.run_duty    = cfg_data_i;
          REG_STOP_DUTY:   regs_q.stop_duty   = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = status_due_q.size();
    end
  end

endmodule

@@ dv/homing_bang_bang_position_servo_top_test.sv @@
// Testbench top: drives events and register settings into the servo, gives the verdict.
`timescale 1ns / 1ps

module homing_bang_bang_position_servo_top_test;
  import svo_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        calm;
  int          fail_count;
  int          pending;
  int          n_edge;
  int          n_index;
  int          n_tick;
  int          n_unused;
  int          n_settings;

  svo_in_if  in_if ();
  svo_out_if out_if ();

  homing_bang_bang_position_servo_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  homing_servo_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL homing_bang_bang_position_servo_top");
    $finish;
  end

  // Status consumer: random stall before each item, none while calm.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
    end
  end

  // Send one event; valid stays high after acceptance so back-to-back items need no toggle.
  task automatic push(input logic [1:0] mode, input logic b, input logic signed [15:0] tgt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.mode         <= mode;
    in_if.b_level      <= b;
    in_if.target_angle <= tgt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    case (mode)
      MODE_EDGE:  n_edge++;
      MODE_INDEX: n_index++;
      MODE_TICK:  n_tick++;
      default:    n_unused++;
    endcase
  endtask

  // Hold the sender until every status item is back, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all four registers; the unused top bit of the 15-bit ones is random.
  task automatic load_settings(input logic [14:0] db, input logic [14:0] lim,
                               input logic [15:0] run, input logic [15:0] stop);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DEADBAND;
    cfg_data <= {1'($urandom_range(0, 1)), db};
    @(negedge clk);
    cfg_idx  <= REG_ANGLE_LIMIT;
    cfg_data <= {1'($urandom_range(0, 1)), lim};
    @(negedge clk);
    cfg_idx  <= REG_RUN_DUTY;
    cfg_data <= run;
    @(negedge clk);
    cfg_idx  <= REG_STOP_DUTY;
    cfg_data <= stop;
    @(negedge clk);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [15:0] pick_target(input int lim, input int db);
    int r;
    int span;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      span = lim + db + 4;
      if (span > 32767) span = 32767;
      return 16'(int'($urandom_range(0, 2 * span)) - span);
    end
    if (r < 8) return 16'($urandom);
    if (r == 8) return 16'sh7FFF;
    return 16'sh8000;
  endfunction

  // Tracking-phase traffic: edges, index pulses, ticks near the target window, noise.
  task automatic run_phase(input int n, input int lim, input int db);
    int r;
    for (int i = 0; i < n; i++) begin
      calm = (i >= 40 && i < 70);
      r = $urandom_range(0, 99);
      if (r < 50)      push(MODE_EDGE, 1'($urandom_range(0, 1)), 16'($urandom));
      else if (r < 55) push(MODE_INDEX, 1'($urandom_range(0, 1)), 16'($urandom));
      else if (r < 95) push(MODE_TICK, 1'($urandom_range(0, 1)), pick_target(lim, db));
      else             push(ModeUnused, 1'($urandom_range(0, 1)), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [14:0] db;
    logic [14:0] lim;
    rst_n              = 1'b0;
    calm               = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_DEADBAND;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_EDGE;
    in_if.b_level      = 1'b0;
    in_if.target_angle = '0;
    n_edge     = 0;
    n_index    = 0;
    n_tick     = 0;
    n_unused   = 0;
    n_settings = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // homing at reset defaults, unused mode, wrap below zero
    push(MODE_TICK, 1'b0, 16'sd0);
    push(ModeUnused, 1'b1, 16'sh7FFF);
    push(MODE_EDGE, 1'b0, 16'sd0);
    push(MODE_EDGE, 1'b1, 16'sh8000);
    drain();
    load_settings(15'd0, 15'd1, 16'hFFFF, 16'h0000);
    // climb to the reversal threshold, cross it, then tick again past it
    repeat (4) push(MODE_EDGE, 1'b1, 16'sd0);
    push(MODE_TICK, 1'b0, 16'sd0);
    push(MODE_EDGE, 1'b1, 16'sd0);
    push(MODE_TICK, 1'b1, 16'sd0);
    push(MODE_EDGE, 1'b0, 16'sd0);
    push(MODE_TICK, 1'b0, 16'sd0);
    // index, then the tick that enters tracking
    push(MODE_INDEX, 1'b0, 16'sd0);
    push(MODE_EDGE, 1'b1, 16'sd0);
    push(MODE_TICK, 1'b0, 16'sd0);
    // clamp at both ends, on target, index while tracking
    push(MODE_TICK, 1'b0, 16'sh7FFF);
    push(MODE_TICK, 1'b1, 16'sh8000);
    push(MODE_TICK, 1'b0, 16'sd1);
    push(MODE_INDEX, 1'b1, 16'shFFFF);
    push(MODE_TICK, 1'b0, 16'sh8000);
    push(MODE_TICK, 1'b0, 16'sh7FFF);
    push(ModeUnused, 1'b0, 16'shFFFF);
    push(MODE_EDGE, 1'b0, 16'sh5555);

    drain();
    load_settings(15'd3, 15'd20, 16'd1234, 16'd4321);
    run_phase(150, 20, 3);
    drain();
    load_settings(15'd0, 15'd0, 16'h0000, 16'hFFFF);
    run_phase(150, 0, 0);
    drain();
    load_settings(15'h7FFF, 15'h7FFF, 16'hFFFF, 16'h0000);
    run_phase(150, 32767, 32767);
    drain();
    load_settings(15'd1, 15'd5, 16'($urandom), 16'($urandom));
    run_phase(150, 5, 1);
    drain();
    db  = 15'($urandom_range(0, 10));
    lim = 15'($urandom_range(0, 50));
    load_settings(db, lim, 16'($urandom), 16'($urandom));
    run_phase(150, int'(lim), int'(db));

    drain();
    repeat (10) @(posedge clk);
    $display("Run: %0d events (%0d edges, %0d index pulses, %0d ticks, %0d unused mode)",
             n_edge + n_index + n_tick + n_unused, n_edge, n_index, n_tick, n_unused);
    $display("Run: homing with reversal, then tracking under %0d register settings",
             n_settings);
    if (fail_count == 0) begin
      $display("PASS homing_bang_bang_position_servo_top");
    end else begin
      $display("FAIL homing_bang_bang_position_servo_top");
    end
    $finish;
  end

endmodule
